FILE: design/cps_pkg.sv
// Shared constants, types and codes for the current profile setpoint generator.
package cps_pkg;

  localparam int MAX_POINTS = 16;
  localparam int DAC_BITS   = 12;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int TIME_W     = 32;
  localparam int CUR_W      = 16;
  localparam int GAIN_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_W     = GAIN_W + CUR_W;
  localparam int ENTRY_W    = TIME_W + CUR_W;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [DAC_BITS-1:0] DAC_FULL = {DAC_BITS{1'b1}};
  localparam logic [GAIN_W-1:0]   GAIN_ONE = GAIN_W'(1) << FRAC_BITS;

  localparam logic       FUNC_LOAD = 1'b0;
  localparam logic       FUNC_EVAL = 1'b1;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_STEP   = 2'd1;

  typedef enum logic [2:0] {
    REG_MANUAL_EN,
    REG_MANUAL_CODE,
    REG_CURVE_MODE,
    REG_POINT_COUNT,
    REG_CODE_GAIN,
    REG_MA_GAIN
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAST,
    ST_SCAN,
    ST_MULD,
    ST_DIV,
    ST_MULC,
    ST_MULM,
    ST_DONE
  } state_t;

endpackage

FILE: design/cps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/cps_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
module cps_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cps_pkg::GAIN_W-1:0]  a,
  input  logic [cps_pkg::CUR_W-1:0]   b,
  output logic                        done,
  output logic [cps_pkg::PROD_W-1:0]  prod
);

  localparam int CW = $clog2(cps_pkg::CUR_W);

  logic [cps_pkg::GAIN_W-1:0] a_r;
  logic [cps_pkg::GAIN_W-1:0] hi_r;
  logic [cps_pkg::CUR_W-1:0]  lo_r;
  logic [CW-1:0]              cnt_r;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [cps_pkg::GAIN_W:0]   sum;
  logic                       last;

  assign sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);
  assign last = (cnt_r == CW'(cps_pkg::CUR_W - 1));

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && last) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      hi_r  <= '0;
      lo_r  <= b;
      cnt_r <= '0;
    end else if (busy_r) begin
      hi_r  <= sum[cps_pkg::GAIN_W:1];
      lo_r  <= {sum[0], lo_r[cps_pkg::CUR_W-1:1]};
      cnt_r <= cnt_r + CW'(1);
    end
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("multiplier done lasted more than one cycle");

  a_run_length: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !last && !start |=> busy_r)
    else $error("multiplier stopped before its last step");

endmodule

FILE: design/cps_div.sv
// Restoring divider: one quotient bit per cycle, quotient known to fit CUR_W bits.
module cps_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cps_pkg::PROD_W-1:0]  dividend,
  input  logic [cps_pkg::TIME_W-1:0]  divisor,
  output logic                        done,
  output logic [cps_pkg::CUR_W-1:0]   quot
);

  localparam int CW = $clog2(cps_pkg::CUR_W);

  logic [cps_pkg::TIME_W-1:0] div_r;
  logic [cps_pkg::TIME_W-1:0] rem_r;
  logic [cps_pkg::CUR_W-1:0]  q_r;
  logic [CW-1:0]              cnt_r;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [cps_pkg::TIME_W+1:0] trial;
  logic                       ge;
  logic                       last;

  // partial remainder with the next dividend bit shifted in, less the divisor
  assign trial = {1'b0, rem_r, q_r[cps_pkg::CUR_W-1]} - {2'b00, div_r};
  assign ge    = !trial[cps_pkg::TIME_W+1];
  assign last  = (cnt_r == CW'(cps_pkg::CUR_W - 1));

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && last) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // upper dividend bits are below the divisor, so only CUR_W steps are needed
  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      rem_r <= dividend[cps_pkg::PROD_W-1:cps_pkg::CUR_W];
      q_r   <= dividend[cps_pkg::CUR_W-1:0];
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? trial[cps_pkg::TIME_W-1:0]
                  : {rem_r[cps_pkg::TIME_W-2:0], q_r[cps_pkg::CUR_W-1]};
      q_r   <= {q_r[cps_pkg::CUR_W-2:0], ge};
      cnt_r <= cnt_r + CW'(1);
    end
  end

  assign done = done_r;
  assign quot = q_r;

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < div_r))
    else $error("partial remainder not below divisor");

  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done lasted more than one cycle");

endmodule

FILE: design/current_profile_setpoint.sv
// Top level: config registers, point table, search sequencer and result register.
//
//  channel  dir  handshake          payload
//  in_      in   in_valid/in_ready  func, point_index, point_time, point_current, query_time
//  out_     out  out_valid/out_ready target_current, dac_code
//  cfg      in   psel/penable/pready paddr, pwrite, pwdata, prdata (APB, 6 regs at 4*i)
//
// A load writes its slot; the sequencer stays idle. An evaluate goes straight to the result
// for an empty table or unused mode; manual mode and a query at or past the last point run
// one serial multiply; step mode scans, then multiplies; linear scans, then multiplies,
// divides and multiplies again. The scan reads one slot a cycle and may find no segment.
// Reset is synchronous, active low; the point table has no reset and no clearing pass.
// A finished result waits in the output register; the next result waits until it is taken.
module current_profile_setpoint (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic [3:0]                    in_point_index,
  input  logic [cps_pkg::TIME_W-1:0]    in_point_time,
  input  logic [cps_pkg::CUR_W-1:0]     in_point_current,
  input  logic [cps_pkg::TIME_W-1:0]    in_query_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cps_pkg::CUR_W-1:0]     out_target_current,
  output logic [cps_pkg::DAC_BITS-1:0]  out_dac_code,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cps_pkg::ADDR_W-1:0]    paddr,
  input  logic [cps_pkg::DATA_W-1:0]    pwdata,
  output logic [cps_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  // configuration
  logic                          manual_en_r;
  logic [cps_pkg::DAC_BITS-1:0]  manual_code_r;
  logic [1:0]                    curve_mode_r;
  logic [cps_pkg::CNT_W-1:0]     point_count_r;
  logic [cps_pkg::GAIN_W-1:0]    code_gain_r;
  logic [cps_pkg::GAIN_W-1:0]    ma_gain_r;
  cps_pkg::cfg_idx_t             cfg_idx;
  logic                          cfg_wr;

  // sequencer
  cps_pkg::state_t               st_r, st_nxt;
  logic [cps_pkg::TIME_W-1:0]    q_r, q_nxt;
  logic [cps_pkg::PT_AW-1:0]     idx_r, idx_nxt;
  logic [cps_pkg::TIME_W-1:0]    prev_t_r, prev_t_nxt;
  logic [cps_pkg::CUR_W-1:0]     prev_c_r, prev_c_nxt;
  logic [cps_pkg::CUR_W-1:0]     c0_r, c0_nxt;
  logic [cps_pkg::TIME_W-1:0]    span_r, span_nxt;
  logic                          neg_r, neg_nxt;
  logic [cps_pkg::CUR_W-1:0]     cur_r, cur_nxt;
  logic [cps_pkg::DAC_BITS-1:0]  code_r, code_nxt;
  logic [cps_pkg::CNT_W-1:0]     n;
  logic [cps_pkg::CUR_W-1:0]     c_interp;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic [cps_pkg::CUR_W-1:0]     out_cur_r;
  logic [cps_pkg::DAC_BITS-1:0]  out_code_r;
  logic                          out_load;

  // point table
  logic                          ram_we;
  logic [cps_pkg::PT_AW-1:0]     ram_raddr;
  logic [cps_pkg::ENTRY_W-1:0]   ram_rdata;
  logic [cps_pkg::TIME_W-1:0]    rd_t;
  logic [cps_pkg::CUR_W-1:0]     rd_c;

  // arithmetic units
  logic                          mul_start, mul_done;
  logic [cps_pkg::GAIN_W-1:0]    mul_a;
  logic [cps_pkg::CUR_W-1:0]     mul_b;
  logic [cps_pkg::PROD_W-1:0]    mul_prod;
  logic                          div_start, div_done;
  logic [cps_pkg::CUR_W-1:0]     div_quot;

  //--------------------------------------------------------------------------
  // Configuration port
  assign pready  = 1'b1;
  assign cfg_idx = cps_pkg::cfg_idx_t'(paddr[cps_pkg::ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      manual_en_r   <= 1'b0;
      manual_code_r <= '0;
      curve_mode_r  <= cps_pkg::MODE_LINEAR;
      point_count_r <= '0;
      code_gain_r   <= cps_pkg::GAIN_ONE;
      ma_gain_r     <= cps_pkg::GAIN_ONE;
    end else if (cfg_wr) begin
      case (cfg_idx)
        cps_pkg::REG_MANUAL_EN:   manual_en_r   <= pwdata[0];
        cps_pkg::REG_MANUAL_CODE: manual_code_r <= pwdata[cps_pkg::DAC_BITS-1:0];
        cps_pkg::REG_CURVE_MODE:  curve_mode_r  <= pwdata[1:0];
        cps_pkg::REG_POINT_COUNT: point_count_r <= pwdata[cps_pkg::CNT_W-1:0];
        cps_pkg::REG_CODE_GAIN:   code_gain_r   <= pwdata[cps_pkg::GAIN_W-1:0];
        cps_pkg::REG_MA_GAIN:     ma_gain_r     <= pwdata[cps_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      cps_pkg::REG_MANUAL_EN:   prdata = cps_pkg::DATA_W'(manual_en_r);
      cps_pkg::REG_MANUAL_CODE: prdata = cps_pkg::DATA_W'(manual_code_r);
      cps_pkg::REG_CURVE_MODE:  prdata = cps_pkg::DATA_W'(curve_mode_r);
      cps_pkg::REG_POINT_COUNT: prdata = cps_pkg::DATA_W'(point_count_r);
      cps_pkg::REG_CODE_GAIN:   prdata = cps_pkg::DATA_W'(code_gain_r);
      cps_pkg::REG_MA_GAIN:     prdata = cps_pkg::DATA_W'(ma_gain_r);
      default:                  prdata = '0;
    endcase
  end

  //--------------------------------------------------------------------------
  // Point table: {time, current} per slot
  assign ram_we = in_valid && in_ready && (in_func == cps_pkg::FUNC_LOAD) &&
                  (32'(in_point_index) < cps_pkg::MAX_POINTS);

  cps_ram #(
    .WIDTH (cps_pkg::ENTRY_W),
    .DEPTH (cps_pkg::MAX_POINTS)
  ) u_points (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cps_pkg::PT_AW'(in_point_index)),
    .wdata ({in_point_time, in_point_current}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_t = ram_rdata[cps_pkg::ENTRY_W-1:cps_pkg::CUR_W];
  assign rd_c = ram_rdata[cps_pkg::CUR_W-1:0];

  cps_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  cps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mul_prod),
    .divisor  (span_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  //--------------------------------------------------------------------------
  // Sequencer
  assign n = (point_count_r > cps_pkg::CNT_W'(cps_pkg::MAX_POINTS)) ?
             cps_pkg::CNT_W'(cps_pkg::MAX_POINTS) : point_count_r;
  assign c_interp = neg_r ? (c0_r - div_quot) : (c0_r + div_quot);
  assign in_ready = (st_r == cps_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= cps_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r      <= q_nxt;
    idx_r    <= idx_nxt;
    prev_t_r <= prev_t_nxt;
    prev_c_r <= prev_c_nxt;
    c0_r     <= c0_nxt;
    span_r   <= span_nxt;
    neg_r    <= neg_nxt;
    cur_r    <= cur_nxt;
    code_r   <= code_nxt;
    if (out_load) begin
      out_cur_r  <= cur_r;
      out_code_r <= code_r;
    end
  end

  always_comb begin
    st_nxt     = st_r;
    q_nxt      = q_r;
    idx_nxt    = idx_r;
    prev_t_nxt = prev_t_r;
    prev_c_nxt = prev_c_r;
    c0_nxt     = c0_r;
    span_nxt   = span_r;
    neg_nxt    = neg_r;
    cur_nxt    = cur_r;
    code_nxt   = code_r;
    ram_raddr  = '0;
    mul_start  = 1'b0;
    mul_a      = code_gain_r;
    mul_b      = '0;
    div_start  = 1'b0;
    out_load   = 1'b0;

    case (st_r)
      cps_pkg::ST_IDLE: begin
        if (in_valid && in_func == cps_pkg::FUNC_EVAL) begin
          q_nxt = in_query_time;
          if (manual_en_r) begin
            mul_start = 1'b1;
            mul_a     = ma_gain_r;
            mul_b     = cps_pkg::CUR_W'(manual_code_r);
            code_nxt  = manual_code_r;
            st_nxt    = cps_pkg::ST_MULM;
          end else if (curve_mode_r > cps_pkg::MODE_STEP || n == '0) begin
            cur_nxt  = '0;
            code_nxt = '0;
            st_nxt   = cps_pkg::ST_DONE;
          end else begin
            ram_raddr = cps_pkg::PT_AW'(n - cps_pkg::CNT_W'(1));
            st_nxt    = cps_pkg::ST_LAST;
          end
        end
      end

      // last point first: at or past it the curve is flat
      cps_pkg::ST_LAST: begin
        if (n == cps_pkg::CNT_W'(1) || rd_t <= q_r) begin
          cur_nxt   = rd_c;
          mul_start = 1'b1;
          mul_b     = rd_c;
          st_nxt    = cps_pkg::ST_MULC;
        end else begin
          idx_nxt = '0;
          st_nxt  = cps_pkg::ST_SCAN;
        end
      end

      // rdata holds slot idx_r, prev_* holds slot idx_r-1
      cps_pkg::ST_SCAN: begin
        if (idx_r != '0 && prev_t_r <= q_r && rd_t > q_r) begin
          c0_nxt = prev_c_r;
          if (curve_mode_r == cps_pkg::MODE_STEP) begin
            cur_nxt   = prev_c_r;
            mul_start = 1'b1;
            mul_b     = prev_c_r;
            st_nxt    = cps_pkg::ST_MULC;
          end else begin
            span_nxt  = rd_t - prev_t_r;
            neg_nxt   = (rd_c < prev_c_r);
            mul_start = 1'b1;
            mul_a     = q_r - prev_t_r;
            mul_b     = (rd_c < prev_c_r) ? (prev_c_r - rd_c) : (rd_c - prev_c_r);
            st_nxt    = cps_pkg::ST_MULD;
          end
        end else if (cps_pkg::CNT_W'(idx_r) == n - cps_pkg::CNT_W'(1)) begin
          // no ascending segment holds the query
          cur_nxt  = '0;
          code_nxt = '0;
          st_nxt   = cps_pkg::ST_DONE;
        end else begin
          prev_t_nxt = rd_t;
          prev_c_nxt = rd_c;
          ram_raddr  = idx_r + cps_pkg::PT_AW'(1);
          idx_nxt    = idx_r + cps_pkg::PT_AW'(1);
        end
      end

      cps_pkg::ST_MULD: begin
        if (mul_done) begin
          div_start = 1'b1;
          st_nxt    = cps_pkg::ST_DIV;
        end
      end

      cps_pkg::ST_DIV: begin
        if (div_done) begin
          cur_nxt   = c_interp;
          mul_start = 1'b1;
          mul_b     = c_interp;
          st_nxt    = cps_pkg::ST_MULC;
        end
      end

      cps_pkg::ST_MULC: begin
        if (mul_done) begin
          if (|mul_prod[cps_pkg::PROD_W-1:cps_pkg::FRAC_BITS+cps_pkg::DAC_BITS]) begin
            code_nxt = cps_pkg::DAC_FULL;
          end else begin
            code_nxt = mul_prod[cps_pkg::FRAC_BITS+cps_pkg::DAC_BITS-1:cps_pkg::FRAC_BITS];
          end
          st_nxt = cps_pkg::ST_DONE;
        end
      end

      cps_pkg::ST_MULM: begin
        if (mul_done) begin
          if (|mul_prod[cps_pkg::PROD_W-1:cps_pkg::FRAC_BITS+cps_pkg::CUR_W]) begin
            cur_nxt = '1;
          end else begin
            cur_nxt = mul_prod[cps_pkg::FRAC_BITS+cps_pkg::CUR_W-1:cps_pkg::FRAC_BITS];
          end
          st_nxt = cps_pkg::ST_DONE;
        end
      end

      cps_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          st_nxt   = cps_pkg::ST_IDLE;
        end
      end

      default: st_nxt = cps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_target_current = out_cur_r;
  assign out_dac_code       = out_code_r;

  //--------------------------------------------------------------------------
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == cps_pkg::ST_DONE && out_valid_r && !out_ready |=> st_r == cps_pkg::ST_DONE)
    else $error("result finished while the previous request was still held");

  a_eval_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == cps_pkg::FUNC_EVAL |=> !in_ready)
    else $error("evaluate request did not hold off the input");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == cps_pkg::ST_SCAN |-> cps_pkg::CNT_W'(idx_r) < n)
    else $error("table scan ran past the last breakpoint");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == cps_pkg::ST_DONE)
    else $error("result register loaded outside the finishing step");

endmodule

FILE: tb/sv/tb_current_profile_setpoint.sv
// Self-checking testbench for the current profile setpoint generator.
`timescale 1ns / 1ps

module tb_current_profile_setpoint;
  import cps_pkg::*;

  localparam logic [1:0] MODE_MONO  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int DRAIN_PAD   = 100;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int PRINT_CAP   = 20;
  localparam longint LIMIT_NS = 64'd10_000_000;

  typedef struct packed {
    logic                func;
    logic [3:0]          index;
    logic [TIME_W-1:0]   ptime;
    logic [CUR_W-1:0]    pma;
    logic [TIME_W-1:0]   qtime;
  } sp_req_t;

  typedef struct packed {
    logic [CUR_W-1:0]    ma;
    logic [DAC_BITS-1:0] code;
  } setpoint_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_func = FUNC_LOAD;
  logic [3:0]          in_point_index = '0;
  logic [TIME_W-1:0]   in_point_time = '0;
  logic [CUR_W-1:0]    in_point_current = '0;
  logic [TIME_W-1:0]   in_query_time = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CUR_W-1:0]    out_target_current;
  logic [DAC_BITS-1:0] out_dac_code;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // configuration and point table as the block should hold them
  logic                cfg_manual = 1'b0;
  logic [DAC_BITS-1:0] cfg_manual_code = '0;
  logic [1:0]          cfg_mode = MODE_LINEAR;
  logic [CNT_W-1:0]    cfg_count = '0;
  logic [GAIN_W-1:0]   cfg_code_gain = GAIN_ONE;
  logic [GAIN_W-1:0]   cfg_ma_gain = GAIN_ONE;
  logic [TIME_W-1:0]   tbl_time [MAX_POINTS];
  logic [CUR_W-1:0]    tbl_ma [MAX_POINTS];

  sp_req_t   setpoint_requests[$];
  setpoint_t setpoints_due[$];
  sp_req_t   on_offer;
  setpoint_t want_sp;
  int        requests_sent = 0;
  int        requests_taken = 0;
  int        fail_count = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  logic      hold_off = 1'b0;

  current_profile_setpoint dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_point_index     (in_point_index),
    .in_point_time      (in_point_time),
    .in_point_current   (in_point_current),
    .in_query_time      (in_query_time),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_target_current (out_target_current),
    .out_dac_code       (out_dac_code),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [CUR_W-1:0] curve_ma(logic [TIME_W-1:0] q);
    int               n;
    int               i;
    logic [CUR_W-1:0] c0;
    logic [CUR_W-1:0] c1;
    logic [63:0]      span;
    logic [63:0]      dt;
    logic [63:0]      mag;
    n = (cfg_count > MAX_POINTS) ? MAX_POINTS : int'(cfg_count);
    if (cfg_mode > MODE_STEP || n == 0) return '0;
    if (n == 1 || tbl_time[n-1] <= q) return tbl_ma[n-1];
    for (i = 0; i + 1 < n; i++) begin
      if (tbl_time[i] <= q && tbl_time[i+1] > q) begin
        c0 = tbl_ma[i];
        c1 = tbl_ma[i+1];
        if (cfg_mode == MODE_STEP || tbl_time[i+1] == tbl_time[i]) return c0;
        // on a selected segment the span is positive and the offset is not negative
        span = 64'(tbl_time[i+1] - tbl_time[i]);
        dt   = 64'(q - tbl_time[i]);
        if (c1 >= c0) begin
          mag = 64'(c1 - c0) * dt / span;
          return c0 + CUR_W'(mag);
        end
        mag = 64'(c0 - c1) * dt / span;
        return c0 - CUR_W'(mag);
      end
    end
    return '0;
  endfunction

  function automatic setpoint_t predict_setpoint(logic [TIME_W-1:0] q);
    setpoint_t   r;
    logic [63:0] prod;
    if (cfg_manual) begin
      r.code = cfg_manual_code;
      prod = (64'(cfg_manual_code) * 64'(cfg_ma_gain)) >> FRAC_BITS;
      r.ma = (prod > 64'hFFFF) ? '1 : CUR_W'(prod);
    end else begin
      r.ma = curve_ma(q);
      prod = (64'(r.ma) * 64'(cfg_code_gain)) >> FRAC_BITS;
      r.code = (prod > 64'(DAC_FULL)) ? DAC_FULL : DAC_BITS'(prod);
    end
    return r;
  endfunction

  function automatic void take_request(sp_req_t r);
    if (r.func == FUNC_LOAD) begin
      tbl_time[r.index] = r.ptime;
      tbl_ma[r.index]   = r.pma;
    end else begin
      setpoints_due.push_back(predict_setpoint(r.qtime));
    end
  endfunction

  task automatic flag_mismatch(string what);
    if (fail_count < PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        take_request(on_offer);
        requests_taken++;
      end
      if (!in_valid || in_ready) begin
        if (setpoint_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_offer = setpoint_requests.pop_front();
          in_valid         <= 1'b1;
          in_func          <= on_offer.func;
          in_point_index   <= on_offer.index;
          in_point_time    <= on_offer.ptime;
          in_point_current <= on_offer.pma;
          in_query_time    <= on_offer.qtime;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (setpoints_due.size() == 0) begin
          flag_mismatch($sformatf("result %0d/%0d with nothing expected",
                                  out_target_current, out_dac_code));
        end else begin
          want_sp = setpoints_due.pop_front();
          if (out_target_current !== want_sp.ma)
            flag_mismatch($sformatf("target_current got %0d want %0d",
                                    out_target_current, want_sp.ma));
          if (out_dac_code !== want_sp.code)
            flag_mismatch($sformatf("dac_code got %0d want %0d",
                                    out_dac_code, want_sp.code));
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic reg_write(cfg_idx_t idx, logic [DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MANUAL_EN:   cfg_manual = val[0];
      REG_MANUAL_CODE: cfg_manual_code = val[DAC_BITS-1:0];
      REG_CURVE_MODE:  cfg_mode = val[1:0];
      REG_POINT_COUNT: cfg_count = val[CNT_W-1:0];
      REG_CODE_GAIN:   cfg_code_gain = val;
      REG_MA_GAIN:     cfg_ma_gain = val;
      default: ;
    endcase
  endtask

  task automatic push_load(int slot, logic [TIME_W-1:0] t, logic [CUR_W-1:0] ma);
    sp_req_t r;
    r.func  = FUNC_LOAD;
    r.index = 4'(slot);
    r.ptime = t;
    r.pma   = ma;
    r.qtime = $urandom;
    setpoint_requests.push_back(r);
    requests_sent++;
  endtask

  task automatic push_eval(logic [TIME_W-1:0] q);
    sp_req_t r;
    r.func  = FUNC_EVAL;
    r.index = 4'($urandom_range(0, 15));
    r.ptime = $urandom;
    r.pma   = CUR_W'($urandom_range(0, 65535));
    r.qtime = q;
    setpoint_requests.push_back(r);
    requests_sent++;
  endtask

  task automatic wait_idle();
    while (requests_taken != requests_sent || setpoints_due.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // Mostly an ascending table for the live slots followed by queries aimed at it,
  // with stray loads and queries mixed in.
  task automatic fill_random(int quota);
    logic [TIME_W-1:0] tt [MAX_POINTS];
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] q;
    int n, pushed, i, k, evals;
    bit first;
    n = (cfg_count > MAX_POINTS) ? MAX_POINTS : int'(cfg_count);
    pushed = 0;
    first = 1'b1;
    while (pushed < quota) begin
      k = $urandom_range(99);
      if (!first && k < 8) begin
        i = $urandom_range(0, MAX_POINTS - 1);
        t = $urandom;
        tt[i] = t;
        push_load(i, t, CUR_W'($urandom_range(0, 65535)));
        pushed++;
      end else if (!first && k < 14) begin
        push_eval($urandom);
        pushed++;
      end else begin
        first = 1'b0;
        k = $urandom_range(99);
        t = (k < 30) ? '0 : (k < 80) ? TIME_W'($urandom_range(0, 1000)) : TIME_W'($urandom);
        for (i = 0; i < n; i++) begin
          tt[i] = t;
          k = $urandom_range(99);
          push_load(i, t, (k < 10) ? '0 : (k < 20) ? '1 : CUR_W'($urandom_range(0, 65535)));
          k = $urandom_range(99);
          // a step of zero gives equal neighbouring times; big steps may wrap
          if (k < 10) t = t + $urandom_range(0, 2);
          else if (k < 70) t = t + $urandom_range(1, 500);
          else t = t + $urandom_range(1, 32'h1000_0000);
        end
        pushed += n;
        evals = $urandom_range(4, 16);
        repeat (evals) begin
          k = $urandom_range(99);
          if (n < 2 || k < 5) begin
            q = $urandom;
          end else if (k < 15) begin
            q = tt[$urandom_range(0, n - 1)];
          end else if (k < 22) begin
            q = $urandom_range(0, tt[0]);
          end else if (k < 30) begin
            q = $urandom_range(tt[n-1], 32'hFFFF_FFFF);
          end else begin
            i = $urandom_range(0, n - 2);
            q = tt[i] + $urandom_range(0, tt[i+1] - tt[i]);
          end
          push_eval(q);
        end
        pushed += evals;
      end
    end
  endtask

  initial begin
    #(LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int i, p, k;
    logic [DATA_W-1:0] v;
    for (i = 0; i < MAX_POINTS; i++) begin
      tbl_time[i] = '0;
      tbl_ma[i]   = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty table after reset
    push_eval('0);
    push_eval('1);
    // fill every slot so that no later scan meets an unwritten one
    for (i = 0; i < MAX_POINTS; i++)
      push_load(i, (i == MAX_POINTS - 1) ? 32'hFFFF_FFFF : 32'(100 * (i + 1)),
                (i == MAX_POINTS - 1) ? 16'hFFFF :
                (i % 2 == 1) ? 16'hFFFF - 16'(i * 1000) : 16'(i * 1000));
    wait_idle();

    // before the first point, on a point, rising and falling segments, past the last
    reg_write(REG_POINT_COUNT, 4);
    push_eval(0);
    push_eval(100);
    push_eval(150);
    push_eval(250);
    push_eval(400);
    push_eval('1);
    wait_idle();
    reg_write(REG_CURVE_MODE, MODE_STEP);
    push_eval(150);
    push_eval(250);
    wait_idle();
    reg_write(REG_CURVE_MODE, MODE_MONO);
    push_eval(150);
    wait_idle();
    reg_write(REG_CURVE_MODE, MODE_SPARE);
    push_eval(150);
    wait_idle();

    // oversized count acts as full table; widest segment at the top of time
    reg_write(REG_CURVE_MODE, MODE_LINEAR);
    reg_write(REG_POINT_COUNT, 31);
    push_eval('1);
    push_eval(32'hFFFF_FFFE);
    wait_idle();
    reg_write(REG_POINT_COUNT, 1);
    push_eval(0);
    wait_idle();

    // code gain extremes: zero, saturating, and a mid value
    reg_write(REG_POINT_COUNT, 16);
    reg_write(REG_CODE_GAIN, 0);
    push_eval(150);
    wait_idle();
    reg_write(REG_CODE_GAIN, 32'hFFFF_FFFF);
    push_eval(150);
    wait_idle();
    reg_write(REG_CODE_GAIN, 4096);
    push_eval(150);
    wait_idle();

    // manual drive: current saturation, zero gain, zero code
    reg_write(REG_MANUAL_EN, 1);
    reg_write(REG_MANUAL_CODE, 12'hFFF);
    reg_write(REG_MA_GAIN, 32'hFFFF_FFFF);
    push_eval(150);
    wait_idle();
    reg_write(REG_MA_GAIN, 0);
    push_eval(150);
    wait_idle();
    reg_write(REG_MANUAL_CODE, 0);
    reg_write(REG_MA_GAIN, GAIN_ONE);
    push_eval(150);
    wait_idle();

    // out-of-order table: a later point earlier in time than the first
    reg_write(REG_MANUAL_EN, 0);
    reg_write(REG_POINT_COUNT, 3);
    push_load(1, 50, 16'hFFFF);
    push_eval(75);
    push_eval(20);
    wait_idle();

    for (p = 0; p < RAND_PHASES; p++) begin
      @(posedge clk);
      case (p % 4)
        0: begin send_idle_pct <= 0;  stall_pct <= 0;  end
        1: begin send_idle_pct <= 48; stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  stall_pct <= 48; end
        default: begin send_idle_pct <= 8; stall_pct <= 8; end
      endcase
      reg_write(REG_MANUAL_EN, (p % 6 == 5));
      v = (p % 4 == 0) ? 32'hFFF : (p % 4 == 1) ? 32'h0 : $urandom_range(0, 4095);
      reg_write(REG_MANUAL_CODE, v);
      reg_write(REG_CURVE_MODE, (p == 6) ? MODE_MONO :
                                ($urandom_range(0, 1) ? MODE_STEP : MODE_LINEAR));
      case (p % 5)
        0: v = MAX_POINTS;
        1: v = $urandom_range(2, 8);
        2: v = $urandom_range(MAX_POINTS + 1, 31);
        3: v = $urandom_range(0, 1);
        default: v = $urandom_range(2, MAX_POINTS);
      endcase
      reg_write(REG_POINT_COUNT, v);
      k = $urandom_range(99);
      v = (k < 20) ? $urandom : (k < 30) ? GAIN_ONE : $urandom_range(256, 6000);
      reg_write(REG_CODE_GAIN, v);
      k = $urandom_range(99);
      v = (k < 20) ? $urandom : $urandom_range(0, 32'h0020_0000);
      reg_write(REG_MA_GAIN, v);
      fill_random(PHASE_ITEMS);
      if (p == 4) begin
        // receiver stays away long enough for requests to back up
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
      wait_idle();
    end

    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
design/cps_pkg.sv
design/cps_ram.sv
design/cps_mul.sv
design/cps_div.sv
design/current_profile_setpoint.sv
tb/sv/tb_current_profile_setpoint.sv
